@@ rtl/lru_tile_cache_directory_macros.svh @@
// ----------------------------------------------------------------------------
// LRU tile cache directory: assertion macros
// Concurrent check wrappers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LRU_TILE_CACHE_DIRECTORY_MACROS_SVH
`define LRU_TILE_CACHE_DIRECTORY_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge out of reset
`define LRUTC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication
`define LRUTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LRUTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRUTC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define LRUTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LRUTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/lrutc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrutc_pkg
// Shared widths, codes and cell control type of the LRU tile cache directory.
// ----------------------------------------------------------------------------
package lrutc_pkg;

    // Field widths
    localparam int ROW_W      = 20;
    localparam int TILE_SHIFT = 8;                   // log2 of rows per tile
    localparam int TILE_ROWS  = 256;
    localparam int TILE_W     = ROW_W - TILE_SHIFT;  // tile number width
    localparam int ROWS_W     = TILE_SHIFT + 1;      // 0..TILE_ROWS
    localparam int CAP_W      = 7;
    localparam int DIM_W      = 7;
    localparam int ELEM_W     = 15;                  // elements of one tile
    localparam int OFS_W      = 14;
    localparam int SLOT_OUT_W = 6;
    localparam int BYTE_SHIFT = 3;                   // 8 bytes per element
    localparam int BYTE_W     = 24;
    localparam int HIT_W      = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY   = 2'd0,
        CFG_TOTAL_ROWS = 2'd1,
        CFG_DIMENSIONS = 2'd2
    } cfg_index_t;

    // How the cell row reorders on an update
    typedef enum logic [1:0] {
        MODE_HIT   = 2'd0,   // move the matching entry to the front
        MODE_FILL  = 2'd1,   // insert at front, row grows by one
        MODE_EVICT = 2'd2    // insert at front, last valid entry drops out
    } mode_t;

    typedef struct packed {
        logic  upd;
        mode_t mode;
    } cell_ctl_t;

endpackage

@@ rtl/lrutc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrutc_cell
// One directory entry in recency order; compares its tag with the lookup and
// takes its upstream neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module lrutc_cell
    import lrutc_pkg::*;
#(
    parameter int SLOT_W = 6
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctl_t            ctl,
    input  logic [TILE_W-1:0]    lookup_tile,
    input  logic                 found_in,
    input  logic                 prev_valid,
    input  logic [TILE_W-1:0]    prev_tile,
    input  logic [SLOT_W-1:0]    prev_slot,
    input  logic [ELEM_W-1:0]    prev_elems,
    output logic                 found_out,
    output logic                 match,
    output logic                 valid,
    output logic [TILE_W-1:0]    tile,
    output logic [SLOT_W-1:0]    slot,
    output logic [ELEM_W-1:0]    elems
);

    logic                valid_reg;
    logic [TILE_W-1:0]   tile_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ELEM_W-1:0]   elems_reg;
    logic                shift;

    // Tag compare and first-match chain
    assign match     = valid_reg && (tile_reg == lookup_tile);
    assign found_out = found_in | match;

    // Does this cell take its neighbor's entry
    always_comb
    begin
        unique case (ctl.mode)
            MODE_HIT:   shift = !found_in;    // at or ahead of the hit
            MODE_FILL:  shift = prev_valid;   // up to the first free cell
            MODE_EVICT: shift = valid_reg;    // across all valid cells
            default:    shift = 1'b0;
        endcase
    end

    // Entry valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.upd && shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (ctl.upd && shift)
        begin
            tile_reg  <= prev_tile;
            slot_reg  <= prev_slot;
            elems_reg <= prev_elems;
        end
    end

    assign valid = valid_reg;
    assign tile  = tile_reg;
    assign slot  = slot_reg;
    assign elems = elems_reg;

endmodule

@@ rtl/lru_tile_cache_directory.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tile_cache_directory
// Fully associative LRU directory of row tiles built as a row of entry cells.
// ----------------------------------------------------------------------------
// Each row id transfer is captured, then looked up and applied:
// all cells compare their tile tag at once and the row shifts by one place up
// to the hit or insert point, so the recency order updates in a single step.
// The row id is held in row_id_reg, the result in a result register; a new
// row id is taken in the cycle its predecessor is looked up, so the sustained
// rate is one row id per cycle while results are drained. The tag compare and
// shift across MAX_TILES cells set the cycle time. Out-of-range row ids
// return status 1 and leave all state alone.
// ----------------------------------------------------------------------------
`include "lru_tile_cache_directory_macros.svh"

module lru_tile_cache_directory
    import lrutc_pkg::*;
#(
    parameter int MAX_TILES = 64
)(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ROW_W-1:0]        cfg_data,
    // request channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [ROW_W-1:0]        row_id,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    status,
    output logic                    hit,
    output logic [SLOT_OUT_W-1:0]   slot,
    output logic [ROW_W-1:0]        tile_first_row,
    output logic [OFS_W-1:0]        element_offset,
    output logic [ELEM_W-1:0]       load_elements,
    output logic                    evicted,
    output logic [ROW_W-1:0]        evicted_first_row,
    output logic [HIT_W-1:0]        hits_total,
    output logic [BYTE_W-1:0]       peak_cached_bytes
);

    localparam int SLOT_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W  = $clog2(MAX_TILES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Configuration registers
    logic [CAP_W-1:0]  capacity_reg;
    logic [ROW_W-1:0]  total_rows_reg;
    logic [DIM_W-1:0]  dimensions_reg;

    // Handshake and item registers
    logic              busy_reg;
    logic [ROW_W-1:0]  row_id_reg;
    logic              fire;
    logic              accept;

    // Directory bookkeeping
    logic [CNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0] cached_reg;
    logic [BYTE_W-1:0] peak_reg;
    logic [HIT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  count_next;
    logic [BYTE_W-1:0] cached_next;
    logic [BYTE_W-1:0] peak_next;
    logic [HIT_W-1:0]  hits_next;

    // Result registers
    logic                  out_valid_reg;
    logic                  status_reg;
    logic                  hit_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [ROW_W-1:0]      first_reg;
    logic [OFS_W-1:0]      offset_reg;
    logic [ELEM_W-1:0]     load_reg;
    logic                  evicted_reg;
    logic [ROW_W-1:0]      ev_first_reg;

    // Cell row chain; index 0 is the new entry fed into the front
    logic                ch_valid [0:MAX_TILES];
    logic [TILE_W-1:0]   ch_tile  [0:MAX_TILES];
    logic [SLOT_W-1:0]   ch_slot  [0:MAX_TILES];
    logic [ELEM_W-1:0]   ch_elems [0:MAX_TILES];
    logic                ch_found [0:MAX_TILES];
    logic [MAX_TILES-1:0] match_vec;
    logic [MAX_TILES-1:0] valid_vec;
    logic [MAX_TILES-1:0] last_vec;
    logic [MAX_TILES:0]   valid_plus;
    cell_ctl_t            ctl;

    // Lookup datapath
    logic [TILE_W-1:0]     tile_lu;
    logic [ROW_W-1:0]      first_row;
    logic                  in_range;
    logic [ROW_W-1:0]      rows_avail;
    logic [ROWS_W-1:0]     rows_left;
    logic [ELEM_W-1:0]     elems_new;
    logic [ELEM_W-1:0]     offset_prod;
    logic [CMP_W-1:0]      cap_raw;
    logic [CMP_W-1:0]      cap_max;
    logic [CMP_W-1:0]      cap_eff;
    logic                  full;
    logic                  hit_any;
    logic [SLOT_W-1:0]     hit_slot;
    logic [ELEM_W-1:0]     hit_elems;
    logic [TILE_W-1:0]     ev_tile;
    logic [SLOT_W-1:0]     ev_slot;
    logic [ELEM_W-1:0]     ev_elems;
    logic [SLOT_W-1:0]     new_slot;
    logic [BYTE_W-1:0]     gone_bytes;
    logic [BYTE_W-1:0]     cached_base;
    logic [BYTE_W:0]       cached_sum;

    // Handshake: one item held, processed when the result register is free
    assign fire     = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_W'(2);
            total_rows_reg <= ROW_W'(2);
            dimensions_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:   capacity_reg   <= cfg_data[CAP_W-1:0];
                CFG_TOTAL_ROWS: total_rows_reg <= cfg_data;
                CFG_DIMENSIONS: dimensions_reg <= cfg_data[DIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Tile split, range check and products
    always_comb
    begin
        tile_lu     = row_id_reg[ROW_W-1:TILE_SHIFT];
        first_row   = {tile_lu, {TILE_SHIFT{1'b0}}};
        in_range    = row_id_reg < total_rows_reg;
        rows_avail  = total_rows_reg - first_row;
        rows_left   = (rows_avail > ROW_W'(TILE_ROWS)) ? ROWS_W'(TILE_ROWS)
                                                      : rows_avail[ROWS_W-1:0];
        elems_new   = ELEM_W'(rows_left) * ELEM_W'(dimensions_reg);
        offset_prod = ELEM_W'(row_id_reg[TILE_SHIFT-1:0]) * ELEM_W'(dimensions_reg);
    end

    // Effective capacity and fullness
    always_comb
    begin
        cap_raw = CMP_W'(capacity_reg);
        cap_max = CMP_W'(MAX_TILES);
        if (cap_raw < CMP_W'(2))
        begin
            cap_eff = CMP_W'(2);
        end
        else if (cap_raw > cap_max)
        begin
            cap_eff = cap_max;
        end
        else
        begin
            cap_eff = cap_raw;
        end
        full = CMP_W'(count_reg) >= cap_eff;
    end

    // Select hit entry and last valid entry (both one-hot)
    assign last_vec   = valid_vec & ~(valid_vec >> 1);
    assign valid_plus = {1'b0, valid_vec} + (MAX_TILES + 1)'(1);

    always_comb
    begin
        hit_any   = 1'b0;
        hit_slot  = '0;
        hit_elems = '0;
        ev_tile   = '0;
        ev_slot   = '0;
        ev_elems  = '0;
        for (int i = 0; i < MAX_TILES; i++)
        begin
            hit_any = hit_any | match_vec[i];
            if (match_vec[i])
            begin
                hit_slot  = hit_slot | ch_slot[i+1];
                hit_elems = hit_elems | ch_elems[i+1];
            end
            if (last_vec[i])
            begin
                ev_tile  = ev_tile | ch_tile[i+1];
                ev_slot  = ev_slot | ch_slot[i+1];
                ev_elems = ev_elems | ch_elems[i+1];
            end
        end
    end

    // Cell control
    always_comb
    begin
        ctl.upd = fire && in_range;
        if (hit_any)
        begin
            ctl.mode = MODE_HIT;
            new_slot = hit_slot;
        end
        else if (full)
        begin
            ctl.mode = MODE_EVICT;
            new_slot = ev_slot;
        end
        else
        begin
            ctl.mode = MODE_FILL;
            new_slot = count_reg[SLOT_W-1:0];
        end
    end

    // New front entry
    assign ch_valid[0] = 1'b1;
    assign ch_tile[0]  = tile_lu;
    assign ch_slot[0]  = new_slot;
    assign ch_elems[0] = hit_any ? hit_elems : elems_new;
    assign ch_found[0] = 1'b0;

    // Cell row
    for (genvar g = 0; g < MAX_TILES; g++)
    begin : g_cell
        lrutc_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .lookup_tile (tile_lu),
            .found_in    (ch_found[g]),
            .prev_valid  (ch_valid[g]),
            .prev_tile   (ch_tile[g]),
            .prev_slot   (ch_slot[g]),
            .prev_elems  (ch_elems[g]),
            .found_out   (ch_found[g+1]),
            .match       (match_vec[g]),
            .valid       (ch_valid[g+1]),
            .tile        (ch_tile[g+1]),
            .slot        (ch_slot[g+1]),
            .elems       (ch_elems[g+1])
        );
        assign valid_vec[g] = ch_valid[g+1];
    end

    // Byte accounting, hit count and fill count
    always_comb
    begin
        gone_bytes  = BYTE_W'({ev_elems, {BYTE_SHIFT{1'b0}}});
        cached_base = cached_reg;
        if (ctl.mode == MODE_EVICT)
        begin
            cached_base = (gone_bytes >= cached_reg) ? '0 : cached_reg - gone_bytes;
        end
        cached_sum = {1'b0, cached_base}
                   + (BYTE_W + 1)'({elems_new, {BYTE_SHIFT{1'b0}}});

        count_next  = count_reg;
        cached_next = cached_reg;
        peak_next   = peak_reg;
        hits_next   = hits_reg;
        if (ctl.upd)
        begin
            if (hit_any)
            begin
                if (hits_reg != {HIT_W{1'b1}})
                begin
                    hits_next = hits_reg + HIT_W'(1);
                end
            end
            else
            begin
                cached_next = cached_sum[BYTE_W] ? {BYTE_W{1'b1}} : cached_sum[BYTE_W-1:0];
                if (cached_next > peak_reg)
                begin
                    peak_next = cached_next;
                end
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            cached_reg    <= '0;
            peak_reg      <= '0;
            hits_reg      <= '0;
        end
        else
        begin
            busy_reg      <= accept || (busy_reg && !fire);
            out_valid_reg <= fire || (out_valid_reg && out_stall);
            count_reg     <= count_next;
            cached_reg    <= cached_next;
            peak_reg      <= peak_next;
            hits_reg      <= hits_next;
        end
    end

    // Captured row id
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_id_reg <= row_id;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= !in_range;
            hit_reg      <= in_range && hit_any;
            slot_reg     <= in_range ? SLOT_OUT_W'(new_slot) : '0;
            first_reg    <= in_range ? first_row : '0;
            offset_reg   <= in_range ? offset_prod[OFS_W-1:0] : '0;
            load_reg     <= (in_range && !hit_any) ? elems_new : '0;
            evicted_reg  <= in_range && !hit_any && full;
            ev_first_reg <= (in_range && !hit_any && full)
                            ? {ev_tile, {TILE_SHIFT{1'b0}}} : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign hit               = hit_reg;
    assign slot              = slot_reg;
    assign tile_first_row    = first_reg;
    assign element_offset    = offset_reg;
    assign load_elements     = load_reg;
    assign evicted           = evicted_reg;
    assign evicted_first_row = ev_first_reg;
    assign hits_total        = hits_reg;
    assign peak_cached_bytes = peak_reg;

    // Checks
    `LRUTC_ASSERT_ALWAYS(a_tag_unique, clk, rst_n, $onehot0(match_vec), "tile cached twice")
    `LRUTC_ASSERT_ALWAYS(a_valid_prefix, clk, rst_n, $onehot(valid_plus), "valid entries not a prefix")
    `LRUTC_ASSERT_ALWAYS(a_peak_bound, clk, rst_n, peak_reg >= cached_reg, "peak below cached bytes")
    `LRUTC_ASSERT_NEXT(a_fill_count, clk, rst_n, ctl.upd && (ctl.mode == MODE_FILL), count_reg == $past(count_reg) + CNT_W'(1), "fill did not grow count")
    `LRUTC_ASSERT_NEXT(a_hits_mono, clk, rst_n, 1'b1, hits_reg >= $past(hits_reg), "hit count went down")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU tile cache directory. A directed list of
// row ids and register writes runs first, then random phases under several
// register settings and handshake pressure. Every result transfer is
// compared field by field against listed values or an in-bench LRU model.
// ----------------------------------------------------------------------------
module tb_top;
    import lrutc_pkg::*;

    localparam int DIR_DEPTH = 64;
    localparam int PHASE_ROWS = 45;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [BYTE_W-1:0] BYTE_LIMIT = '1;

    typedef struct packed {
        logic                  status;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ROW_W-1:0]      first_row;
        logic [OFS_W-1:0]      offset;
        logic [ELEM_W-1:0]     load;
        logic                  ev;
        logic [ROW_W-1:0]      ev_row;
        logic [HIT_W-1:0]      hits;
        logic [BYTE_W-1:0]     peak;
    } dir_result_t;

    typedef enum bit {STEP_ROW, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [ROW_W-1:0]      value;
        bit                    known;
        dir_result_t           res;
    } dir_step_t;

    // DUT ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ROW_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ROW_W-1:0]        row_id = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    status;
    logic                    hit;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [ROW_W-1:0]        tile_first_row;
    logic [OFS_W-1:0]        element_offset;
    logic [ELEM_W-1:0]       load_elements;
    logic                    evicted;
    logic [ROW_W-1:0]        evicted_first_row;
    logic [HIT_W-1:0]        hits_total;
    logic [BYTE_W-1:0]       peak_cached_bytes;

    // Directory model state, index 0 is most recent
    logic [TILE_W-1:0]       dir_tile  [DIR_DEPTH];
    logic                    dir_valid [DIR_DEPTH];
    logic [SLOT_OUT_W-1:0]   dir_slot  [DIR_DEPTH];
    int unsigned             dir_elems [DIR_DEPTH];
    logic [BYTE_W-1:0]       bytes_held = '0;
    logic [BYTE_W-1:0]       bytes_peak = '0;
    logic [HIT_W-1:0]        hit_tally = '0;
    logic [CAP_W-1:0]        cfg_cap = 7'd2;
    logic [ROW_W-1:0]        cfg_rows = 20'd2;
    logic [DIM_W-1:0]        cfg_dims = 7'd1;

    dir_result_t             pending_results [$];
    dir_step_t               directed_steps [$];
    int                      mismatch_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    bit                      hold_request = 1'b0;
    int                      hold_left = 0;

    lru_tile_cache_directory DUT (.*);

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Shift entries 0..pos-1 down one place and put the tile in front
    function automatic void promote(input int pos, input logic [TILE_W-1:0] tile,
                                    input logic [SLOT_OUT_W-1:0] sl,
                                    input int unsigned elems);
        for (int i = pos; i > 0; i--)
        begin
            dir_tile[i]  = dir_tile[i-1];
            dir_valid[i] = dir_valid[i-1];
            dir_slot[i]  = dir_slot[i-1];
            dir_elems[i] = dir_elems[i-1];
        end
        dir_tile[0]  = tile;
        dir_valid[0] = 1'b1;
        dir_slot[0]  = sl;
        dir_elems[0] = elems;
    endfunction

    // Look one row id up in the model directory and update its state
    function automatic dir_result_t lookup_tile(input logic [ROW_W-1:0] id);
        dir_result_t             r;
        logic [TILE_W-1:0]       tile;
        logic [ROW_W-1:0]        first;
        logic [31:0]             prod;
        logic [SLOT_OUT_W-1:0]   sl;
        int unsigned             held, pos, cap, last, rows_left, elems;
        longint unsigned         sum, gone;
        bit                      found;
        r = '0;
        if (id >= cfg_rows)
        begin
            r.status = 1'b1;
        end
        else
        begin
            tile = id[ROW_W-1:TILE_SHIFT];
            first = {tile, {TILE_SHIFT{1'b0}}};
            prod = (id - first) * cfg_dims;
            r.first_row = first;
            r.offset = prod[OFS_W-1:0];
            held = 0;
            pos = 0;
            found = 1'b0;
            for (int i = 0; i < DIR_DEPTH; i++)
            begin
                if (dir_valid[i])
                begin
                    held++;
                    if (!found && dir_tile[i] == tile)
                    begin
                        found = 1'b1;
                        pos = i;
                    end
                end
            end
            if (found)
            begin
                if (hit_tally != '1)
                    hit_tally++;
                sl = dir_slot[pos];
                promote(pos, tile, sl, dir_elems[pos]);
                r.hit = 1'b1;
                r.slot = sl;
            end
            else
            begin
                // effective capacity is clamped to [2, DIR_DEPTH]
                cap = (cfg_cap < 2) ? 2 : ((cfg_cap > DIR_DEPTH) ? DIR_DEPTH : cfg_cap);
                if (held >= cap)
                begin
                    last = held - 1;
                    gone = longint'(dir_elems[last]) * 8;
                    r.ev = 1'b1;
                    r.ev_row = {dir_tile[last], {TILE_SHIFT{1'b0}}};
                    bytes_held = (gone >= bytes_held) ? '0 : BYTE_W'(bytes_held - gone);
                    sl = dir_slot[last];
                    dir_valid[last] = 1'b0;
                    held = last;
                end
                else
                begin
                    sl = SLOT_OUT_W'(held);
                end
                rows_left = cfg_rows - first;
                if (rows_left > TILE_ROWS)
                    rows_left = TILE_ROWS;
                elems = rows_left * cfg_dims;
                sum = longint'(bytes_held) + longint'(elems) * 8;
                bytes_held = (sum > BYTE_LIMIT) ? BYTE_LIMIT : BYTE_W'(sum);
                if (bytes_held > bytes_peak)
                    bytes_peak = bytes_held;
                promote((held < DIR_DEPTH) ? held : DIR_DEPTH - 1, tile, sl, elems);
                r.slot = sl;
                r.load = ELEM_W'(elems);
            end
        end
        r.hits = hit_tally;
        r.peak = bytes_peak;
        return r;
    endfunction

    // Register shadow, masked to register widths; unknown indexes are ignored
    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [ROW_W-1:0] val);
        case (idx)
            CFG_CAPACITY:   cfg_cap = val[CAP_W-1:0];
            CFG_TOTAL_ROWS: cfg_rows = val;
            CFG_DIMENSIONS: cfg_dims = val[DIM_W-1:0];
            default: ;
        endcase
    endfunction

    // Directed list builders
    function automatic void add_row(input logic [ROW_W-1:0] id);
        dir_step_t s;
        s.kind = STEP_ROW;
        s.idx = '0;
        s.value = id;
        s.known = 1'b0;
        s.res = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_known(input logic [ROW_W-1:0] id, input logic st,
                                      input logic h, input logic [SLOT_OUT_W-1:0] sl,
                                      input logic [ROW_W-1:0] fr,
                                      input logic [OFS_W-1:0] ofs,
                                      input logic [ELEM_W-1:0] ld, input logic ev,
                                      input logic [ROW_W-1:0] er,
                                      input logic [HIT_W-1:0] hc,
                                      input logic [BYTE_W-1:0] pk);
        dir_step_t s;
        s.kind = STEP_ROW;
        s.idx = '0;
        s.value = id;
        s.known = 1'b1;
        s.res = '{st, h, sl, fr, ofs, ld, ev, er, hc, pk};
        directed_steps.push_back(s);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [ROW_W-1:0] val);
        dir_step_t s;
        s.kind = STEP_CFG;
        s.idx = idx;
        s.value = val;
        s.known = 1'b0;
        s.res = '0;
        directed_steps.push_back(s);
    endfunction

    // Pick a row id: mostly from a working set a bit larger than the capacity
    function automatic logic [ROW_W-1:0] pick_row(input int unsigned base,
                                                  input int unsigned span);
        int unsigned sel, id;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            id = $urandom_range(cfg_rows, 20'hFFFFF);
        else if (sel < 14)
            id = $urandom_range(0, 20'hFFFFF);
        else
        begin
            id = (base + $urandom_range(0, span - 1)) * TILE_ROWS
                 + $urandom_range(0, TILE_ROWS - 1);
            if (id >= cfg_rows)
                id = cfg_rows - 1;
        end
        return ROW_W'(id);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Register write; the enable stays high until release_cfg
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_cfg(idx, val);
    endtask

    task automatic release_cfg();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering row ids and wait until every result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One row id transfer, with random idle cycles ahead of it
    task automatic send_row(input logic [ROW_W-1:0] id, input bit known,
                            input dir_result_t known_res);
        dir_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        row_id <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = lookup_tile(id);
        pending_results.push_back(known ? known_res : r);
    endtask

    task automatic compare_result();
        dir_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result transfer with nothing expected");
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("hit", want.hit, hit);
        check_field("slot", want.slot, slot);
        check_field("tile_first_row", want.first_row, tile_first_row);
        check_field("element_offset", want.offset, element_offset);
        check_field("load_elements", want.load, load_elements);
        check_field("evicted", want.ev, evicted);
        check_field("evicted_first_row", want.ev_row, evicted_first_row);
        check_field("hits_total", want.hits, hits_total);
        check_field("peak_cached_bytes", want.peak, peak_cached_bytes);
    endtask

    // Result side: check transfers, then pick the next stall value
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                compare_result();
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        step_kind_t            last_kind;
        int unsigned           base, span, tiles, cap_eff;
        logic [ROW_W-1:0]      cap_w, rows_w, dims_w;

        for (int i = 0; i < DIR_DEPTH; i++)
        begin
            dir_tile[i] = '0;
            dir_valid[i] = 1'b0;
            dir_slot[i] = '0;
            dir_elems[i] = 0;
        end

        // Directed list; at reset: capacity 2, 2 rows, 1 value per row
        add_known(20'd0, 0, 0, 0, 20'd0, 14'd0, 15'd2, 0, 20'd0, 32'd0, 24'd16);
        add_known(20'd1, 0, 1, 0, 20'd0, 14'd1, 15'd0, 0, 20'd0, 32'd1, 24'd16);
        add_known(20'd2, 1, 0, 0, 20'd0, 14'd0, 15'd0, 0, 20'd0, 32'd1, 24'd16);
        add_known(20'hFFFFF, 1, 0, 0, 20'd0, 14'd0, 15'd0, 0, 20'd0, 32'd1, 24'd16);
        add_cfg(CFG_TOTAL_ROWS, 20'hFFFFF);
        add_cfg(CFG_DIMENSIONS, 20'd127);
        // last row in range: partial tile, the element offset wraps
        add_known(20'hFFFFE, 0, 0, 1, 20'd1048320, 14'd15874, 15'd32385, 0, 20'd0,
                  32'd1, 24'd259096);
        add_row(20'd256);
        add_row(20'd512);
        add_row(20'd300);
        add_row(20'd0);
        // capacity below the minimum clamps to 2; zero values per row
        add_cfg(CFG_CAPACITY, 20'd0);
        add_cfg(CFG_DIMENSIONS, 20'd0);
        add_row(20'd1024);
        add_row(20'd255);
        add_cfg(CFG_CAPACITY, 20'd1);
        add_cfg(CFG_DIMENSIONS, 20'd64);
        add_row(20'd768);
        add_row(20'd1);
        // capacity above the maximum clamps; spare index is ignored
        add_cfg(CFG_CAPACITY, 20'hFFFFF);
        add_cfg(CFG_SPARE, 20'h5A5A5);
        add_row(20'd1280);
        add_row(20'd1536);
        add_row(20'd1792);
        add_row(20'd2048);
        add_row(20'hFFFFF);
        add_row(20'd0);
        add_row(20'hFFFFE);
        add_cfg(CFG_TOTAL_ROWS, 20'd1000000);
        add_row(20'd999999);
        add_row(20'd1000000);
        add_row(20'hFFFFF);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed list
        last_kind = STEP_ROW;
        for (int n = 0; n < directed_steps.size(); n++)
        begin
            if (directed_steps[n].kind == STEP_CFG)
            begin
                if (last_kind != STEP_CFG)
                    drain_results();
                write_reg(directed_steps[n].idx, directed_steps[n].value);
            end
            else
            begin
                if (last_kind == STEP_CFG)
                    release_cfg();
                send_row(directed_steps[n].value, directed_steps[n].known,
                         directed_steps[n].res);
            end
            last_kind = directed_steps[n].kind;
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < 9; p++)
        begin
            drain_results();
            case (p)
                0: begin cap_w = 20'd2; rows_w = 20'hFFFFF; dims_w = 20'd1; end
                1: begin cap_w = 20'd64; rows_w = ROW_W'($urandom_range(2000, 20'hFFFFF));
                         dims_w = 20'd64; end
                // capacity dropped below the held count
                2: begin cap_w = {13'($urandom_range(0, 8191)), 7'd3}; rows_w = cfg_rows;
                         dims_w = ROW_W'($urandom_range(1, 127)); end
                3: begin cap_w = 20'd0; rows_w = ROW_W'($urandom_range(2, 600));
                         dims_w = 20'd0; end
                4: begin cap_w = 20'hFFFFF; rows_w = 20'hFFFFF; dims_w = 20'hFFFFF; end
                5: begin cap_w = ROW_W'($urandom_range(2, 64));
                         rows_w = ROW_W'($urandom_range(256, 20000));
                         dims_w = ROW_W'($urandom_range(1, 64)); end
                6: begin cap_w = 20'd1; rows_w = 20'd2; dims_w = 20'd127; end
                7: begin cap_w = 20'd64; rows_w = ROW_W'($urandom_range(2, 20'hFFFFF));
                         dims_w = ROW_W'($urandom_range(0, 127)); end
                default: begin cap_w = ROW_W'($urandom_range(0, 127));
                         rows_w = ROW_W'($urandom_range(2, 20'hFFFFF));
                         dims_w = ROW_W'($urandom_range(0, 127)); end
            endcase
            write_reg(CFG_CAPACITY, cap_w);
            write_reg(CFG_TOTAL_ROWS, rows_w);
            write_reg(CFG_DIMENSIONS, dims_w);
            if (p == 8)
                write_reg(CFG_SPARE, ROW_W'($urandom_range(0, 20'hFFFFF)));
            release_cfg();

            send_idle_pct = (p < 3) ? 15 : ((p < 6) ? 77 : 0);
            recv_stall_pct = (p < 3) ? 77 : ((p < 6) ? 15 : 0);
            // long receiver hold-off while row ids keep coming
            if (p == 7)
                hold_request = 1'b1;

            cap_eff = (cfg_cap < 2) ? 2 : ((cfg_cap > DIR_DEPTH) ? DIR_DEPTH : cfg_cap);
            tiles = (cfg_rows + TILE_ROWS - 1) / TILE_ROWS;
            span = cap_eff + cap_eff / 2 + 1;
            if (span > tiles)
                span = tiles;
            base = $urandom_range(0, tiles - span);

            for (int k = 0; k < PHASE_ROWS; k++)
            begin
                // sender pauses mid-phase until every result is back
                if (p == 5 && k == PHASE_ROWS / 2)
                    drain_results();
                send_row(pick_row(base, span), 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
